FILE: sv/rot_pkg.sv
// Package of shared widths, types and the sine and cosine tables for the rotation block.
package rot_pkg;

   localparam int COORD_BITS   = 32;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int UNIT_BITS    = 30;
   localparam int NORM_BITS    = UNIT_BITS;
   localparam int SQ_BITS      = 2 * NORM_BITS;
   localparam int RAD_BITS     = SQ_BITS + 2;
   localparam int ROOT_BITS    = RAD_BITS / 2;
   localparam int NUM_BITS     = NORM_BITS + UNIT_BITS + 1;
   localparam int QUO_BITS     = UNIT_BITS + 1;
   localparam int EXT_BITS     = 38;
   localparam int POS_BITS     = 6;
   localparam int DEG_BITS     = 9;
   localparam int TRIG_BITS    = UNIT_BITS + 1;
   localparam int TRIG_DEPTH   = 90;
   localparam int TRIG_IDX     = 7;
   localparam int TAYLOR_TERMS = 12;

   localparam int FRONT_LAT = 5;
   localparam int ISQ_LAT   = ROOT_BITS;
   localparam int DIV_LAT   = QUO_BITS + 1;
   localparam int MID_LAT   = ISQ_LAT + DIV_LAT;
   localparam int TAIL_LAT  = 9;

   localparam logic [DEG_BITS-1:0] DEG_90  = 9'd90;
   localparam logic [DEG_BITS-1:0] DEG_180 = 9'd180;
   localparam logic [DEG_BITS-1:0] DEG_270 = 9'd270;
   localparam logic [DEG_BITS-1:0] DEG_360 = 9'd360;

   localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
   localparam logic [63:0] DEG_Q60 = PI_Q60 / 180;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [EXT_BITS-1:0]   ext_type;
   typedef logic signed [COORD_BITS-1:0] unit_type;

   typedef struct packed {
      logic                             zero;
      coord_type [2:0]                  a;
      diff_type [2:0]                   v;
      logic [2:0]                       dneg;
      logic [2:0][DIFF_BITS-1:0]        dmag;
      logic [DEG_BITS-1:0]              deg;
      logic [POS_BITS-1:0]              pos;
      quad_type                         quad;
      logic [TRIG_BITS-1:0]             s0;
      logic [TRIG_BITS-1:0]             c0;
      logic [2:0][NORM_BITS-1:0]        am;
      unit_type                         sn;
      unit_type                         cs;
      logic [2:0][SQ_BITS-1:0]          sq;
      logic [RAD_BITS-1:0]              len2;
   } front_type;

   typedef struct packed {
      logic            zero;
      coord_type [2:0] a;
      diff_type [2:0]  v;
      unit_type [2:0]  u;
      unit_type        sn;
      unit_type        cs;
      ext_type         dot;
      ext_type [2:0]   c;
      ext_type [2:0]   par;
      ext_type [2:0]   perp;
   } ctx_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      zero;
   } result_type;

   typedef logic [TRIG_BITS-1:0] trig_tab_type [TRIG_DEPTH];

   // (a*b) >> s with rounding half up, kept to 64 bits.
   function automatic logic [63:0] umul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << (s - 1));
      p = p >> s;
      return p[63:0];
   endfunction

   // Truncating unsigned quotient by shift and subtract; used only to build the tables.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int bi = 63; bi >= 0; bi--) begin
         rem = {rem[63:0], num[bi]};
         if (rem >= {1'b0, den}) begin
            rem     = rem - {1'b0, den};
            quo[bi] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Taylor series for sine or cosine of r degrees, 30 fraction bits.
   function automatic logic [TRIG_BITS-1:0] taylor_q30(input int r, input logic want_cos);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic [63:0]        k;
      logic signed [63:0] acc;
      logic [63:0]        rounded;
      x   = DEG_Q60 * 64'(r);
      x2  = umul_shift(x, x, 60);
      t   = want_cos ? (64'd1 << 60) : x;
      acc = $signed(t);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         k = want_cos ? 64'((2 * n - 1) * (2 * n)) : 64'((2 * n) * (2 * n + 1));
         t = udiv64(umul_shift(t, x2, 60), k);
         if ((n & 1) == 1) begin
            acc = acc - $signed(t);
         end else begin
            acc = acc + $signed(t);
         end
      end
      if (acc < 0) begin
         acc = 64'sd0;
      end
      rounded = (64'(acc) + (64'd1 << 29)) >> 30;
      return rounded[TRIG_BITS-1:0];
   endfunction

   function automatic trig_tab_type make_trig_tab(input logic want_cos);
      trig_tab_type tab;
      for (int r = 0; r < TRIG_DEPTH; r++) begin
         tab[r] = taylor_q30(r, want_cos);
      end
      return tab;
   endfunction

   localparam trig_tab_type SIN_TAB = make_trig_tab(1'b0);
   localparam trig_tab_type COS_TAB = make_trig_tab(1'b1);

endpackage

FILE: sv/rot_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface rot_req_if import rot_pkg::*; ();
   logic                valid;
   logic                ready;
   coord_type           axis_start_x;
   coord_type           axis_start_y;
   coord_type           axis_start_z;
   coord_type           axis_end_x;
   coord_type           axis_end_y;
   coord_type           axis_end_z;
   coord_type           point_x;
   coord_type           point_y;
   coord_type           point_z;
   logic [DEG_BITS-1:0] angle_deg;

   modport source (output valid, axis_start_x, axis_start_y, axis_start_z, axis_end_x,
                   axis_end_y, axis_end_z, point_x, point_y, point_z, angle_deg,
                   input ready);
   modport sink (input valid, axis_start_x, axis_start_y, axis_start_z, axis_end_x,
                 axis_end_y, axis_end_z, point_x, point_y, point_z, angle_deg,
                 output ready);
endinterface

interface rot_rsp_if import rot_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type rot_x;
   coord_type rot_y;
   coord_type rot_z;
   logic      zero_axis;

   modport source (output valid, rot_x, rot_y, rot_z, zero_axis, input ready);
   modport sink (input valid, rot_x, rot_y, rot_z, zero_axis, output ready);
endinterface

FILE: sv/rot_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module rot_isqrt import rot_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [RAD_BITS-1:0]  radicand,
   output logic [ROOT_BITS-1:0] root
);

   logic [RAD_BITS-1:0] n_ff [ISQ_LAT];
   logic [RAD_BITS-1:0] r_ff [ISQ_LAT];
   logic [RAD_BITS-1:0] n_in [ISQ_LAT];
   logic [RAD_BITS-1:0] r_in [ISQ_LAT];

   always_comb begin
      logic [RAD_BITS-1:0] n_prv;
      logic [RAD_BITS-1:0] r_prv;
      logic [RAD_BITS-1:0] bit_v;
      logic [RAD_BITS-1:0] trial;
      for (int i = 0; i < ISQ_LAT; i++) begin
         if (i == 0) begin
            n_prv = radicand;
            r_prv = '0;
         end else begin
            n_prv = n_ff[i-1];
            r_prv = r_ff[i-1];
         end
         bit_v = RAD_BITS'(1) << (2 * (ISQ_LAT - 1 - i));
         trial = r_prv + bit_v;
         if (n_prv >= trial) begin
            n_in[i] = n_prv - trial;
            r_in[i] = (r_prv >> 1) + bit_v;
         end else begin
            n_in[i] = n_prv;
            r_in[i] = r_prv >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < ISQ_LAT; i++) begin
            n_ff[i] <= n_in[i];
            r_ff[i] <= r_in[i];
         end
      end
   end

   assign root = r_ff[ISQ_LAT-1][ROOT_BITS-1:0];

endmodule

FILE: sv/rot_div.sv
// Pipelined restoring divider giving the rounded 30-fraction-bit axis component.
module rot_div import rot_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [NORM_BITS-1:0] am,
   input  logic [ROOT_BITS-1:0] den,
   output logic [QUO_BITS-1:0]  quo
);

   logic [NUM_BITS-1:0]  rem_ff [DIV_LAT];
   logic [ROOT_BITS-1:0] den_ff [DIV_LAT];
   logic [QUO_BITS-1:0]  quo_ff [DIV_LAT];
   logic [NUM_BITS-1:0]  rem_in [DIV_LAT];
   logic [ROOT_BITS-1:0] den_in [DIV_LAT];
   logic [QUO_BITS-1:0]  quo_in [DIV_LAT];

   always_comb begin
      logic [NUM_BITS-1:0] sub;
      for (int j = 0; j < DIV_LAT; j++) begin
         if (j == 0) begin
            // Half the divisor is added up front so that truncation rounds half up.
            rem_in[j] = NUM_BITS'({am, UNIT_BITS'(0)}) + NUM_BITS'(den >> 1);
            den_in[j] = den;
            quo_in[j] = '0;
         end else begin
            sub       = NUM_BITS'(den_ff[j-1]) << (DIV_LAT - 1 - j);
            den_in[j] = den_ff[j-1];
            if (rem_ff[j-1] >= sub) begin
               rem_in[j] = rem_ff[j-1] - sub;
               quo_in[j] = quo_ff[j-1] | (QUO_BITS'(1) << (DIV_LAT - 1 - j));
            end else begin
               rem_in[j] = rem_ff[j-1];
               quo_in[j] = quo_ff[j-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < DIV_LAT; j++) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= den_in[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign quo = quo_ff[DIV_LAT-1];

endmodule

FILE: sv/rot_mul.sv
// Two-stage signed multiply by a 30-fraction-bit factor, rounded half away from zero.
module rot_mul import rot_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  ext_type  a,
   input  unit_type b,
   output ext_type  y
);

   localparam int PROD_BITS = EXT_BITS + COORD_BITS;

   logic [EXT_BITS-1:0]   a_mag;
   logic [COORD_BITS-1:0] b_mag;
   logic [PROD_BITS-1:0]  prod_ff;
   logic                  neg_ff;
   logic [PROD_BITS-1:0]  rnd;
   logic [EXT_BITS-1:0]   r_mag;
   ext_type               y_ff;

   assign a_mag = a[EXT_BITS-1] ? EXT_BITS'(-a) : EXT_BITS'(a);
   assign b_mag = b[COORD_BITS-1] ? COORD_BITS'(-b) : COORD_BITS'(b);
   assign rnd   = (prod_ff + (PROD_BITS'(1) << (UNIT_BITS - 1))) >> UNIT_BITS;
   assign r_mag = rnd[EXT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PROD_BITS'(a_mag) * PROD_BITS'(b_mag);
         neg_ff  <= a[EXT_BITS-1] ^ b[COORD_BITS-1];
         y_ff    <= neg_ff ? -$signed(r_mag) : $signed(r_mag);
      end
   end

   assign y = y_ff;

endmodule

FILE: sv/point_rotation_about_axis.sv
// Top level of the point rotation block: front end, square root, division and Rodrigues tail.
//
// Each request transaction carries an axis start A, an axis end B, a point P (signed fixed
// point, 16 fraction bits) and an angle in whole degrees; each response transaction returns P
// turned counterclockwise about the axis from A towards B, saturated to the 32-bit coordinate
// range, or A with zero_axis set when B equals A. Angles of 360 and above wrap. The block is a
// single pipeline that takes one transaction in every clock cycle while it is not held, and
// returns one result per transaction in order; a request passes through five front-end
// stages, the 31-stage square root of the axis length, the 32-stage divider that normalises
// the axis, nine stages of multiply and add, and the output register. A two-entry output
// buffer lets the block keep accepting while a result waits; only when both entries are
// full does the whole pipeline hold, and nothing is lost or repeated across such a stall.
module point_rotation_about_axis import rot_pkg::*; (
   input logic    clock,
   input logic    reset,
   rot_req_if.sink   req_if,
   rot_rsp_if.source rsp_if
);

   logic en;

   // Front end: differences, magnitude maximum, normalising shift, squares, sum.
   front_type              fr_ff [FRONT_LAT];
   front_type              fr_in [FRONT_LAT];
   logic [FRONT_LAT-1:0]   fv_ff;

   // Side data waiting for the square root and the divider.
   front_type              mid_ff [MID_LAT];
   logic [MID_LAT-1:0]     mid_v_ff;

   // Rodrigues tail.
   ctx_type                ctx_ff [TAIL_LAT];
   ctx_type                ctx_in [TAIL_LAT];
   logic [TAIL_LAT-1:0]    ctx_v_ff;

   logic [ROOT_BITS-1:0]   len;
   logic [QUO_BITS-1:0]    quo [3];

   ext_type                pa [3][3];
   ext_type                pb [3];
   ext_type                t1 [3];
   ext_type                t2 [3];

   result_type             fin;
   result_type             out_ff;
   result_type             skid_ff;
   logic                   out_v_ff;
   logic                   skid_v_ff;

   // The pipeline holds only while the skid entry is occupied.
   assign en           = !skid_v_ff;
   assign req_if.ready = en;

   // Stage 1: differences from the axis start and the wrapped angle.
   always_comb begin
      coord_type pa_c [3];
      coord_type pb_c [3];
      coord_type pp_c [3];
      diff_type  dd;
      pa_c[0] = req_if.axis_start_x;
      pa_c[1] = req_if.axis_start_y;
      pa_c[2] = req_if.axis_start_z;
      pb_c[0] = req_if.axis_end_x;
      pb_c[1] = req_if.axis_end_y;
      pb_c[2] = req_if.axis_end_z;
      pp_c[0] = req_if.point_x;
      pp_c[1] = req_if.point_y;
      pp_c[2] = req_if.point_z;
      fr_in[0] = '0;
      for (int i = 0; i < 3; i++) begin
         dd                  = DIFF_BITS'(pb_c[i]) - DIFF_BITS'(pa_c[i]);
         fr_in[0].a[i]       = pa_c[i];
         fr_in[0].v[i]       = DIFF_BITS'(pp_c[i]) - DIFF_BITS'(pa_c[i]);
         fr_in[0].dneg[i]    = dd[DIFF_BITS-1];
         fr_in[0].dmag[i]    = dd[DIFF_BITS-1] ? DIFF_BITS'(-dd) : DIFF_BITS'(dd);
      end
      fr_in[0].deg = (req_if.angle_deg >= DEG_360) ? req_if.angle_deg - DEG_360
                                                   : req_if.angle_deg;
   end

   // Stage 2: largest magnitude and its leading one, quadrant and table read.
   always_comb begin
      logic [DIFF_BITS-1:0] mx;
      logic [TRIG_IDX-1:0]  rr;
      fr_in[1] = fr_ff[0];
      mx = fr_ff[0].dmag[0];
      if (fr_ff[0].dmag[1] > mx) begin
         mx = fr_ff[0].dmag[1];
      end
      if (fr_ff[0].dmag[2] > mx) begin
         mx = fr_ff[0].dmag[2];
      end
      fr_in[1].zero = (mx == '0);
      fr_in[1].pos  = '0;
      for (int i = 0; i < DIFF_BITS; i++) begin
         if (mx[i]) begin
            fr_in[1].pos = POS_BITS'(i);
         end
      end
      if (fr_ff[0].deg >= DEG_270) begin
         fr_in[1].quad = QUAD_3;
         rr = TRIG_IDX'(fr_ff[0].deg - DEG_270);
      end else if (fr_ff[0].deg >= DEG_180) begin
         fr_in[1].quad = QUAD_2;
         rr = TRIG_IDX'(fr_ff[0].deg - DEG_180);
      end else if (fr_ff[0].deg >= DEG_90) begin
         fr_in[1].quad = QUAD_1;
         rr = TRIG_IDX'(fr_ff[0].deg - DEG_90);
      end else begin
         fr_in[1].quad = QUAD_0;
         rr = TRIG_IDX'(fr_ff[0].deg);
      end
      fr_in[1].s0 = SIN_TAB[rr];
      fr_in[1].c0 = COS_TAB[rr];
   end

   // Stage 3: common shift puts the largest magnitude just below 2^30; quadrant symmetry.
   always_comb begin
      unit_type s0s;
      unit_type c0s;
      fr_in[2] = fr_ff[1];
      for (int i = 0; i < 3; i++) begin
         if (fr_ff[1].pos >= POS_BITS'(NORM_BITS - 1)) begin
            fr_in[2].am[i] = NORM_BITS'(fr_ff[1].dmag[i] >>
                                        (fr_ff[1].pos - POS_BITS'(NORM_BITS - 1)));
         end else begin
            fr_in[2].am[i] = NORM_BITS'(fr_ff[1].dmag[i] <<
                                        (POS_BITS'(NORM_BITS - 1) - fr_ff[1].pos));
         end
      end
      s0s = unit_type'({1'b0, fr_ff[1].s0});
      c0s = unit_type'({1'b0, fr_ff[1].c0});
      case (fr_ff[1].quad)
         QUAD_0: begin
            fr_in[2].sn = s0s;
            fr_in[2].cs = c0s;
         end
         QUAD_1: begin
            fr_in[2].sn = c0s;
            fr_in[2].cs = -s0s;
         end
         QUAD_2: begin
            fr_in[2].sn = -s0s;
            fr_in[2].cs = -c0s;
         end
         default: begin
            fr_in[2].sn = -c0s;
            fr_in[2].cs = s0s;
         end
      endcase
   end

   // Stage 4: squares of the normalised components.
   always_comb begin
      fr_in[3] = fr_ff[2];
      for (int i = 0; i < 3; i++) begin
         fr_in[3].sq[i] = SQ_BITS'(fr_ff[2].am[i]) * SQ_BITS'(fr_ff[2].am[i]);
      end
   end

   // Stage 5: squared length.
   always_comb begin
      fr_in[4] = fr_ff[3];
      fr_in[4].len2 = RAD_BITS'(fr_ff[3].sq[0]) + RAD_BITS'(fr_ff[3].sq[1])
                    + RAD_BITS'(fr_ff[3].sq[2]);
   end

   rot_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (fr_ff[FRONT_LAT-1].len2),
      .root     (len)
   );

   for (genvar gi = 0; gi < 3; gi++) begin : g_div
      rot_div u_div (
         .clock (clock),
         .en    (en),
         .am    (mid_ff[ISQ_LAT-1].am[gi]),
         .den   (len),
         .quo   (quo[gi])
      );
   end

   // Tail entry: signed unit axis. Later stages pick up the multiplier results.
   always_comb begin
      unit_type qs;
      ctx_in[0]      = '0;
      ctx_in[0].zero = mid_ff[MID_LAT-1].zero;
      ctx_in[0].a    = mid_ff[MID_LAT-1].a;
      ctx_in[0].v    = mid_ff[MID_LAT-1].v;
      ctx_in[0].sn   = mid_ff[MID_LAT-1].sn;
      ctx_in[0].cs   = mid_ff[MID_LAT-1].cs;
      for (int i = 0; i < 3; i++) begin
         qs = unit_type'({1'b0, quo[i]});
         ctx_in[0].u[i] = mid_ff[MID_LAT-1].dneg[i] ? -qs : qs;
      end
      for (int k = 1; k < TAIL_LAT; k++) begin
         ctx_in[k] = ctx_ff[k-1];
      end
      // Dot product and cross product from the nine v*u products.
      ctx_in[3].dot  = pa[0][0] + pa[1][1] + pa[2][2];
      ctx_in[3].c[0] = pa[2][1] - pa[1][2];
      ctx_in[3].c[1] = pa[0][2] - pa[2][0];
      ctx_in[3].c[2] = pa[1][0] - pa[0][1];
      // Parallel part and the perpendicular remainder of v.
      for (int i = 0; i < 3; i++) begin
         ctx_in[6].par[i]  = pb[i];
         ctx_in[6].perp[i] = EXT_BITS'(ctx_ff[5].v[i]) - pb[i];
      end
   end

   for (genvar gi = 0; gi < 3; gi++) begin : g_va
      for (genvar gj = 0; gj < 3; gj++) begin : g_vb
         rot_mul u_mul_vu (
            .clock (clock),
            .en    (en),
            .a     (EXT_BITS'(ctx_ff[0].v[gi])),
            .b     (ctx_ff[0].u[gj]),
            .y     (pa[gi][gj])
         );
      end
      rot_mul u_mul_par (
         .clock (clock),
         .en    (en),
         .a     (ctx_ff[3].dot),
         .b     (ctx_ff[3].u[gi]),
         .y     (pb[gi])
      );
      rot_mul u_mul_cos (
         .clock (clock),
         .en    (en),
         .a     (ctx_ff[6].perp[gi]),
         .b     (ctx_ff[6].cs),
         .y     (t1[gi])
      );
      rot_mul u_mul_sin (
         .clock (clock),
         .en    (en),
         .a     (ctx_ff[6].c[gi]),
         .b     (ctx_ff[6].sn),
         .y     (t2[gi])
      );
   end

   // Final sum and saturation; a zero-length axis returns the start point.
   always_comb begin
      ext_type   sum;
      coord_type r [3];
      for (int i = 0; i < 3; i++) begin
         sum = EXT_BITS'(ctx_ff[TAIL_LAT-1].a[i]) + ctx_ff[TAIL_LAT-1].par[i] + t1[i] + t2[i];
         if (ctx_ff[TAIL_LAT-1].zero) begin
            r[i] = ctx_ff[TAIL_LAT-1].a[i];
         end else if (sum > EXT_BITS'($signed({1'b0, {(COORD_BITS-1){1'b1}}}))) begin
            r[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
         end else if (sum < EXT_BITS'($signed({1'b1, {(COORD_BITS-1){1'b0}}}))) begin
            r[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
         end else begin
            r[i] = sum[COORD_BITS-1:0];
         end
      end
      fin.x    = r[0];
      fin.y    = r[1];
      fin.z    = r[2];
      fin.zero = ctx_ff[TAIL_LAT-1].zero;
   end

   // Valid bits travel with the data and are the only pipeline state that reset clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff    <= '0;
         mid_v_ff <= '0;
         ctx_v_ff <= '0;
      end else if (en) begin
         fv_ff    <= {fv_ff[FRONT_LAT-2:0], req_if.valid};
         mid_v_ff <= {mid_v_ff[MID_LAT-2:0], fv_ff[FRONT_LAT-1]};
         ctx_v_ff <= {ctx_v_ff[TAIL_LAT-2:0], mid_v_ff[MID_LAT-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < FRONT_LAT; k++) begin
            fr_ff[k] <= fr_in[k];
         end
         mid_ff[0] <= fr_ff[FRONT_LAT-1];
         for (int k = 1; k < MID_LAT; k++) begin
            mid_ff[k] <= mid_ff[k-1];
         end
         for (int k = 0; k < TAIL_LAT; k++) begin
            ctx_ff[k] <= ctx_in[k];
         end
      end
   end

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_if.ready) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (ctx_v_ff[TAIL_LAT-1]) begin
         if (!out_v_ff || rsp_if.ready) begin
            out_ff   <= fin;
            out_v_ff <= 1'b1;
         end else begin
            skid_ff   <= fin;
            skid_v_ff <= 1'b1;
         end
      end else if (rsp_if.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_if.valid     = out_v_ff;
   assign rsp_if.rot_x     = out_ff.x;
   assign rsp_if.rot_y     = out_ff.y;
   assign rsp_if.rot_z     = out_ff.z;
   assign rsp_if.zero_axis = out_ff.zero;

   // The skid entry is only ever occupied behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry holds a result while the output register is empty");

   // The skid entry fills only when a waiting result was not taken.
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_if.ready))
      else $error("skid entry filled although the output register was free");

   // An accepted transaction always enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> fv_ff[0])
      else $error("accepted transaction did not enter the pipeline");

endmodule
